// ----- design/bsa_pkg.sv -----
`timescale 1ns / 1ps
package bsa_pkg;
    localparam int PROCESSES = 8;
    localparam int RESOURCES = 4;
    localparam int PW = $clog2(PROCESSES);
    localparam int RW = $clog2(RESOURCES);
    localparam logic [10:0] WORK_MAX = 11'd2047;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_AVAIL = 2'd1,
        OP_REQ   = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CLAIM   = 3'd1,
        ST_UNAVAIL = 3'd2,
        ST_UNSAFE  = 3'd3,
        ST_REJECT  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_WINIT, S_WSCAN, S_WPASS, S_ROLLBACK,
        S_RESULT, S_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic decide;
        logic walk_init;
        logic walk_step;
        logic pass_start;
        logic mark_unsafe;
        logic rollback;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        op_t     op;
        logic    imm_done;
        status_t imm_status;
        logic    at_end;
        logic    found;
        logic    complete;
        logic    emit_last;
    } stat_t;
endpackage

// ----- design/bankers_safety_allocator.sv -----
`timescale 1ns / 1ps
// Load, set-available and rejected requests pass a decide state and then offer their
// word from the result state. A safety walk scans the active processes in passes
// until all have finished or a pass finds none that fits.
// One item is worked on at a time; a safe check then emits one word per active process.
// Synchronous active-low reset clears the allocation and need tables, the available vector and the
// configuration to eight processes and four resource types.
module bankers_safety_allocator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [2:0] s_process_index,
    input  logic [1:0] s_resource_index,
    input  logic [7:0] s_value_a,
    input  logic [7:0] s_value_b,
    input  logic [7:0] s_request_0,
    input  logic [7:0] s_request_1,
    input  logic [7:0] s_request_2,
    input  logic [7:0] s_request_3,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [2:0] m_seq_process,
    output logic       m_last
);
    bsa_pkg::cmd_t  cmd;
    bsa_pkg::stat_t st;
    logic           res_walk;

    bsa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .st, .cmd, .res_walk
    );

    bsa_datapath u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_opcode, .s_process_index, .s_resource_index, .s_value_a, .s_value_b,
        .s_req({s_request_3, s_request_2, s_request_1, s_request_0}),
        .cmd, .res_walk, .st, .m_status, .m_seq_process, .m_last
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while a word is pending");
    a_walk_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_seq_process != 3'd0) |-> (m_status == 3'd0))
        else $error("sequence word with bad status");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready) else $error("no return to idle");
endmodule

// ----- design/bsa_ctrl.sv -----
`timescale 1ns / 1ps
module bsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  bsa_pkg::stat_t st,
    output bsa_pkg::cmd_t  cmd,
    output logic           res_walk
);
    bsa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsa_pkg::S_IDLE: if (s_valid) state_next = bsa_pkg::S_DECIDE;
            bsa_pkg::S_DECIDE: begin
                if (st.imm_done) state_next = bsa_pkg::S_RESULT;
                else state_next = bsa_pkg::S_WINIT;
            end
            bsa_pkg::S_WINIT: state_next = bsa_pkg::S_WSCAN;
            bsa_pkg::S_WSCAN: begin
                if (st.complete) begin
                    state_next = (st.op == bsa_pkg::OP_CHECK) ? bsa_pkg::S_EMIT
                                                              : bsa_pkg::S_RESULT;
                end else if (st.at_end) begin
                    state_next = bsa_pkg::S_WPASS;
                end
            end
            bsa_pkg::S_WPASS: begin
                if (!st.found) begin
                    state_next = (st.op == bsa_pkg::OP_REQ) ? bsa_pkg::S_ROLLBACK
                                                            : bsa_pkg::S_RESULT;
                end else begin
                    state_next = bsa_pkg::S_WSCAN;
                end
            end
            bsa_pkg::S_ROLLBACK: state_next = bsa_pkg::S_RESULT;
            bsa_pkg::S_RESULT: if (m_ready) state_next = bsa_pkg::S_IDLE;
            bsa_pkg::S_EMIT: if (m_ready && st.emit_last) state_next = bsa_pkg::S_IDLE;
            default: state_next = bsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        res_walk = 1'b0;
        unique case (state_reg)
            bsa_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            bsa_pkg::S_DECIDE:   cmd.decide = 1'b1;
            bsa_pkg::S_WINIT:    cmd.walk_init = 1'b1;
            bsa_pkg::S_WSCAN:    cmd.walk_step = !st.complete && !st.at_end;
            bsa_pkg::S_WPASS: begin
                cmd.pass_start  = st.found;
                cmd.mark_unsafe = !st.found;
            end
            bsa_pkg::S_ROLLBACK: cmd.rollback = 1'b1;
            bsa_pkg::S_RESULT:   m_valid = 1'b1;
            bsa_pkg::S_EMIT: begin
                m_valid       = 1'b1;
                res_walk      = 1'b1;
                cmd.emit_next = m_ready;
            end
            default: ;
        endcase
    end
endmodule

// ----- design/bsa_datapath.sv -----
`timescale 1ns / 1ps
module bsa_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [3:0]                      cfg_data,
    input  logic [1:0]                      s_opcode,
    input  logic [2:0]                      s_process_index,
    input  logic [1:0]                      s_resource_index,
    input  logic [7:0]                      s_value_a,
    input  logic [7:0]                      s_value_b,
    input  logic [bsa_pkg::RESOURCES*8-1:0] s_req,
    input  bsa_pkg::cmd_t                   cmd,
    input  logic                            res_walk,
    output bsa_pkg::stat_t                  st,
    output logic [2:0]                      m_status,
    output logic [2:0]                      m_seq_process,
    output logic                            m_last
);
    localparam int P = bsa_pkg::PROCESSES;
    localparam int R = bsa_pkg::RESOURCES;
    localparam int PW = bsa_pkg::PW;

    logic [3:0] nproc_cfg_reg;
    logic [2:0] nres_cfg_reg;
    logic [7:0] alloc_reg [P][R];
    logic [7:0] need_reg [P][R];
    logic [7:0] avail_reg [R];
    logic [10:0] work_reg [R];
    logic [P-1:0] fin_reg;
    logic [PW-1:0] seq_reg [P];
    logic [PW:0] count_reg, emit_reg, np;
    // One bit wider than a table index so that the end of a pass is visible.
    logic [PW:0] scan_reg;
    logic found_reg;
    logic [1:0] op_reg;
    logic [2:0] pi_reg;
    logic [1:0] ri_reg;
    logic [7:0] va_reg, vb_reg;
    logic [7:0] req_reg [R];
    bsa_pkg::status_t status_reg;
    logic [R-1:0] ract;
    logic [2:0] nr;
    logic fits, pi_ok, ri_ok;
    logic [R-1:0] over_need, over_avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nproc_cfg_reg <= 4'd8;
            nres_cfg_reg  <= 3'd4;
        end else if (cfg_we) begin
            if (cfg_index) nres_cfg_reg <= cfg_data[2:0];
            else nproc_cfg_reg <= cfg_data;
        end
    end

    always_comb begin
        np = (nproc_cfg_reg == 4'd0) ? (PW+1)'(1)
           : (32'(nproc_cfg_reg) > P) ? (PW+1)'(P) : (PW+1)'(nproc_cfg_reg);
        nr = (nres_cfg_reg == 3'd0) ? 3'd1
           : (32'(nres_cfg_reg) > R) ? 3'(R) : nres_cfg_reg;
        for (int r = 0; r < R; r++) ract[r] = (32'(r) < 32'(nr));
        pi_ok = (32'(pi_reg) < P);
        ri_ok = (32'(ri_reg) < R);
        fits = !fin_reg[scan_reg[PW-1:0]];
        for (int r = 0; r < R; r++) begin
            if (ract[r] && 11'(need_reg[scan_reg[PW-1:0]][r]) > work_reg[r]) fits = 1'b0;
            over_need[r]  = ract[r] && pi_ok && (req_reg[r] > need_reg[pi_reg[PW-1:0]][r]);
            over_avail[r] = ract[r] && (req_reg[r] > avail_reg[r]);
        end
    end

    always_comb begin
        st            = '0;
        st.op         = bsa_pkg::op_t'(op_reg);
        st.at_end     = (count_reg == np) ? 1'b0 : (scan_reg >= np);
        st.found      = found_reg;
        st.complete   = (count_reg == np);
        st.emit_last  = (emit_reg + 1'b1 == np);
        st.imm_done   = 1'b1;
        st.imm_status = bsa_pkg::ST_OK;
        unique case (bsa_pkg::op_t'(op_reg))
            bsa_pkg::OP_LOAD: begin
                if (!pi_ok || !ri_ok || vb_reg > va_reg) st.imm_status = bsa_pkg::ST_REJECT;
            end
            bsa_pkg::OP_AVAIL: ;
            bsa_pkg::OP_REQ: begin
                if (4'(pi_reg) >= 4'(np) || |over_need) st.imm_status = bsa_pkg::ST_CLAIM;
                else if (|over_avail) st.imm_status = bsa_pkg::ST_UNAVAIL;
                else st.imm_done = 1'b0;
            end
            bsa_pkg::OP_CHECK: st.imm_done = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < P; p++) begin
                for (int r = 0; r < R; r++) begin
                    alloc_reg[p][r] <= '0;
                    need_reg[p][r]  <= '0;
                end
            end
            for (int r = 0; r < R; r++) begin
                avail_reg[r] <= '0;
                work_reg[r]  <= '0;
            end
            fin_reg   <= '0;
            count_reg <= '0;
            emit_reg  <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.take) begin
                op_reg <= s_opcode;
                pi_reg <= s_process_index;
                ri_reg <= s_resource_index;
                va_reg <= s_value_a;
                vb_reg <= s_value_b;
                for (int r = 0; r < R; r++) req_reg[r] <= s_req[r*8 +: 8];
            end
            if (cmd.decide) begin
                status_reg <= st.imm_status;
                if (op_reg == bsa_pkg::OP_LOAD && st.imm_status == bsa_pkg::ST_OK) begin
                    alloc_reg[pi_reg[PW-1:0]][ri_reg] <= vb_reg;
                    need_reg[pi_reg[PW-1:0]][ri_reg]  <= va_reg - vb_reg;
                end
                if (op_reg == bsa_pkg::OP_AVAIL && ri_ok) avail_reg[ri_reg] <= va_reg;
                if (op_reg == bsa_pkg::OP_REQ && !st.imm_done) begin
                    for (int r = 0; r < R; r++) begin
                        if (ract[r]) begin
                            avail_reg[r] <= avail_reg[r] - req_reg[r];
                            alloc_reg[pi_reg[PW-1:0]][r] <= alloc_reg[pi_reg[PW-1:0]][r] + req_reg[r];
                            need_reg[pi_reg[PW-1:0]][r]  <= need_reg[pi_reg[PW-1:0]][r] - req_reg[r];
                        end
                    end
                end
            end
            if (cmd.walk_init) begin
                for (int r = 0; r < R; r++) work_reg[r] <= 11'(avail_reg[r]);
                fin_reg   <= '0;
                count_reg <= '0;
                emit_reg  <= '0;
                scan_reg  <= '0;
                found_reg <= 1'b0;
                status_reg <= bsa_pkg::ST_OK;
            end
            if (cmd.walk_step) begin
                if (fits) begin
                    for (int r = 0; r < R; r++) begin
                        if (ract[r]) begin
                            work_reg[r] <= (12'(work_reg[r]) +
                                            12'(alloc_reg[scan_reg[PW-1:0]][r]) >
                                            12'(bsa_pkg::WORK_MAX)) ? bsa_pkg::WORK_MAX
                                         : work_reg[r] + 11'(alloc_reg[scan_reg[PW-1:0]][r]);
                        end
                    end
                    fin_reg[scan_reg[PW-1:0]]   <= 1'b1;
                    seq_reg[count_reg[PW-1:0]]  <= scan_reg[PW-1:0];
                    count_reg                   <= count_reg + 1'b1;
                    found_reg                   <= 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.pass_start) begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.mark_unsafe) status_reg <= bsa_pkg::ST_UNSAFE;
            if (cmd.rollback) begin
                status_reg <= bsa_pkg::ST_UNSAFE;
                for (int r = 0; r < R; r++) begin
                    if (ract[r]) begin
                        avail_reg[r] <= avail_reg[r] + req_reg[r];
                        alloc_reg[pi_reg[PW-1:0]][r] <= alloc_reg[pi_reg[PW-1:0]][r] - req_reg[r];
                        need_reg[pi_reg[PW-1:0]][r]  <= need_reg[pi_reg[PW-1:0]][r] + req_reg[r];
                    end
                end
            end
            if (cmd.emit_next) emit_reg <= emit_reg + 1'b1;
        end
    end

    assign m_status      = res_walk ? 3'(bsa_pkg::ST_OK) : 3'(status_reg);
    assign m_seq_process = res_walk ? 3'(seq_reg[emit_reg[PW-1:0]]) : 3'd0;
    assign m_last        = res_walk ? st.emit_last : 1'b1;
endmodule

// ----- test/tb_bankers_safety_allocator.sv -----
`timescale 1ns / 1ps
module tb_bankers_safety_allocator;

    typedef struct packed {
        bsa_pkg::status_t status;
        logic [2:0]       proc_id;
        logic             last;
    } word_t;

    // Banker's state predictor plus the queue of words it has promised.
    class alloc_scoreboard;
        logic [7:0]  alloc_q[bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
        logic [7:0]  need_q[bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
        logic [7:0]  avail_q[bsa_pkg::RESOURCES];
        logic [3:0]  procs_reg;
        logic [2:0]  res_reg;
        word_t       pending[$];
        int          errors;

        function void clear();
            foreach (alloc_q[p, r]) begin
                alloc_q[p][r] = '0;
                need_q[p][r] = '0;
            end
            foreach (avail_q[r]) avail_q[r] = '0;
            procs_reg = 4'd8;
            res_reg = 3'd4;
            pending.delete();
            errors = 0;
        endfunction

        function int n_procs();
            if (procs_reg < 1) return 1;
            if (procs_reg > bsa_pkg::PROCESSES) return bsa_pkg::PROCESSES;
            return int'(procs_reg);
        endfunction

        function int n_res();
            if (res_reg < 1) return 1;
            if (res_reg > bsa_pkg::RESOURCES) return bsa_pkg::RESOURCES;
            return int'(res_reg);
        endfunction

        function bit walk(output int order[bsa_pkg::PROCESSES]);
            int  work[bsa_pkg::RESOURCES];
            bit  done[bsa_pkg::PROCESSES];
            int  cnt;
            int  np;
            int  nr;
            bit  found;
            bit  fits;
            np = n_procs();
            nr = n_res();
            cnt = 0;
            foreach (order[i]) order[i] = 0;
            foreach (work[r]) work[r] = int'(avail_q[r]);
            foreach (done[p]) done[p] = 0;
            while (cnt < np) begin
                found = 0;
                for (int p = 0; p < np; p++) begin
                    if (done[p]) continue;
                    fits = 1;
                    for (int r = 0; r < nr; r++)
                        if (int'(need_q[p][r]) > work[r]) fits = 0;
                    if (!fits) continue;
                    for (int r = 0; r < nr; r++) begin
                        work[r] += int'(alloc_q[p][r]);
                        if (work[r] > 2047) work[r] = 2047;
                    end
                    order[cnt++] = p;
                    done[p] = 1;
                    found = 1;
                end
                if (!found) return 0;
            end
            return 1;
        endfunction

        function void note(bsa_pkg::op_t op, int pi, int ri, int va, int vb, int req[4]);
            int order[bsa_pkg::PROCESSES];
            int nr;
            bit bad;
            nr = n_res();
            case (op)
                bsa_pkg::OP_LOAD: begin
                    if (vb > va) pending.push_back('{bsa_pkg::ST_REJECT, 3'd0, 1'b1});
                    else begin
                        alloc_q[pi][ri] = 8'(vb);
                        need_q[pi][ri] = 8'(va - vb);
                        pending.push_back('{bsa_pkg::ST_OK, 3'd0, 1'b1});
                    end
                end
                bsa_pkg::OP_AVAIL: begin
                    avail_q[ri] = 8'(va);
                    pending.push_back('{bsa_pkg::ST_OK, 3'd0, 1'b1});
                end
                bsa_pkg::OP_REQ: begin
                    bad = (pi >= n_procs());
                    for (int r = 0; r < nr; r++)
                        if (req[r] > int'(need_q[pi][r])) bad = 1;
                    if (bad) pending.push_back('{bsa_pkg::ST_CLAIM, 3'd0, 1'b1});
                    else begin
                        for (int r = 0; r < nr; r++)
                            if (req[r] > int'(avail_q[r])) bad = 1;
                        if (bad) pending.push_back('{bsa_pkg::ST_UNAVAIL, 3'd0, 1'b1});
                        else begin
                            for (int r = 0; r < nr; r++) begin
                                avail_q[r] = avail_q[r] - 8'(req[r]);
                                alloc_q[pi][r] = alloc_q[pi][r] + 8'(req[r]);
                                need_q[pi][r] = need_q[pi][r] - 8'(req[r]);
                            end
                            if (walk(order)) pending.push_back('{bsa_pkg::ST_OK, 3'd0, 1'b1});
                            else begin
                                for (int r = 0; r < nr; r++) begin
                                    avail_q[r] = avail_q[r] + 8'(req[r]);
                                    alloc_q[pi][r] = alloc_q[pi][r] - 8'(req[r]);
                                    need_q[pi][r] = need_q[pi][r] + 8'(req[r]);
                                end
                                pending.push_back('{bsa_pkg::ST_UNSAFE, 3'd0, 1'b1});
                            end
                        end
                    end
                end
                default: begin
                    if (!walk(order)) pending.push_back('{bsa_pkg::ST_UNSAFE, 3'd0, 1'b1});
                    else
                        for (int i = 0; i < n_procs(); i++)
                            pending.push_back('{bsa_pkg::ST_OK, 3'(order[i]),
                                                i == n_procs() - 1});
                end
            endcase
        endfunction

        function void check(word_t got);
            word_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word status=%0d seq=%0d last=%0d", $time,
                         got.status, got.proc_id, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.proc_id !== want.proc_id) begin
                $display("%0t: seq_process expected %0d actual %0d", $time, want.proc_id,
                         got.proc_id);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_opcode;
    logic [2:0] s_process_index;
    logic [1:0] s_resource_index;
    logic [7:0] s_value_a;
    logic [7:0] s_value_b;
    logic [7:0] s_request_0;
    logic [7:0] s_request_1;
    logic [7:0] s_request_2;
    logic [7:0] s_request_3;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [2:0] m_seq_process;
    logic       m_last;

    alloc_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    longint cycle_count;

    bankers_safety_allocator dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 600000) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus an optional long hold-off counted here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check('{bsa_pkg::status_t'(m_status), m_seq_process, m_last});
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_cfg(bit idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == 1'b0) sb.procs_reg = val;
        else sb.res_reg = val[2:0];
        @(posedge aclk);
    endtask

    // The last word offered may still be sitting on the bus, so valid drops first.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send(bsa_pkg::op_t op, int pi, int ri, int va, int vb, int r0, int r1,
                        int r2, int r3);
        int req[4];
        req = '{r0, r1, r2, r3};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_process_index <= 3'(pi);
        s_resource_index <= 2'(ri);
        s_value_a <= 8'(va);
        s_value_b <= 8'(vb);
        s_request_0 <= 8'(r0);
        s_request_1 <= 8'(r1);
        s_request_2 <= 8'(r2);
        s_request_3 <= 8'(r3);
        do @(posedge aclk); while (!s_ready);
        sb.note(op, pi, ri, va, vb, req);
    endtask

    // Mostly small numbers so that requests and walks actually succeed.
    function automatic int small_val();
        return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
    endfunction

    task automatic random_item();
        int kind;
        int va;
        kind = $urandom_range(99);
        if (kind < 30) begin
            va = small_val();
            send(bsa_pkg::OP_LOAD, $urandom_range(7), $urandom_range(3), va,
                 ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(va),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
        end else if (kind < 45)
            send(bsa_pkg::OP_AVAIL, $urandom_range(7), $urandom_range(3), small_val() + 4,
                 $urandom_range(255), $urandom_range(255), 0, 0, 0);
        else if (kind < 80)
            send(bsa_pkg::OP_REQ, $urandom_range(7), $urandom_range(3), $urandom_range(255),
                 $urandom_range(255), $urandom_range(3), $urandom_range(3),
                 $urandom_range(3), ($urandom_range(15) == 0) ? 255 : $urandom_range(3));
        else
            send(bsa_pkg::OP_CHECK, $urandom_range(7), $urandom_range(3), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255));
    endtask

    initial begin
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_opcode = '0;
        s_process_index = '0;
        s_resource_index = '0;
        s_value_a = '0;
        s_value_b = '0;
        s_request_0 = '0;
        s_request_1 = '0;
        s_request_2 = '0;
        s_request_3 = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty tables are safe, then extremes and each failure path.
        send(bsa_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_LOAD, 7, 3, 255, 255, 0, 0, 0, 0);
        send(bsa_pkg::OP_LOAD, 0, 0, 5, 6, 0, 0, 0, 0);
        send(bsa_pkg::OP_LOAD, 0, 0, 255, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_AVAIL, 0, 3, 255, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_AVAIL, 0, 0, 0, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_REQ, 0, 0, 0, 0, 1, 0, 0, 0);
        send(bsa_pkg::OP_REQ, 0, 0, 0, 0, 0, 0, 0, 1);
        send(bsa_pkg::OP_AVAIL, 0, 0, 255, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_REQ, 0, 0, 0, 0, 255, 0, 0, 0);
        send(bsa_pkg::OP_LOAD, 1, 1, 10, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_AVAIL, 0, 1, 10, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_REQ, 1, 0, 0, 0, 0, 5, 0, 0);
        send(bsa_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_AVAIL, 0, 1, 0, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        write_cfg(1'b0, 4'd2);
        write_cfg(1'b1, 4'd1);
        send(bsa_pkg::OP_REQ, 5, 0, 0, 0, 0, 0, 0, 0);
        send(bsa_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 25; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: begin write_cfg(1'b0, 4'd8); write_cfg(1'b1, 4'd4); end
                1: begin write_cfg(1'b0, 4'd0); write_cfg(1'b1, 4'd0); end
                2: begin write_cfg(1'b0, 4'd15); write_cfg(1'b1, 4'd7); end
                3: begin write_cfg(1'b0, 4'd1); write_cfg(1'b1, 4'd2); end
                4: begin write_cfg(1'b0, 4'd5); write_cfg(1'b1, 4'd3); end
                default: begin write_cfg(1'b0, 4'd8); write_cfg(1'b1, 4'd4); end
            endcase
            if (ph == 2) hold_cycles = 400;
            repeat (52) random_item();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- bankers_safety_allocator.f -----
design/bsa_pkg.sv
design/bsa_ctrl.sv
design/bsa_datapath.sv
design/bankers_safety_allocator.sv
test/tb_bankers_safety_allocator.sv
